// ----- design/tws_pkg.sv -----
// Package with the shared types and constants of the schedule matcher.
`timescale 1ns / 1ps
package tws_pkg;

  localparam int PERIODS = 8;
  localparam int IDX_W   = $clog2(PERIODS);
  localparam int CNT_W   = 4;

  localparam logic [1:0]         FORCED_TYPE   = 2'd2;
  localparam logic signed [15:0] FORCED_MIN    = 16'sd32000;
  localparam logic signed [15:0] FORCED_MAX    = 16'sd100;
  localparam logic signed [7:0]  LIMIT_OFF     = 8'sd100;
  localparam logic signed [11:0] GATE_FLOOR_Q4 = -12'sd1600;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [2:0]         entry_index;
    logic [11:0]        entry_start;
    logic [11:0]        entry_end;
    logic [1:0]         entry_type;
    logic signed [15:0] entry_power_min;
    logic signed [15:0] entry_power_max;
    logic signed [7:0]  entry_temp_low_limit;
    logic signed [7:0]  entry_temp_high_limit;
    logic [11:0]        query_time;
    logic signed [11:0] query_temperature;
  } tws_in_t;

  typedef struct packed {
    logic [1:0]         active_type;
    logic [1:0]         gated_type;
    logic signed [15:0] threshold_low;
    logic signed [15:0] threshold_high;
  } tws_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } tws_state_t;

  typedef struct packed {
    logic write_entry;
    logic start_query;
    logic scan_step;
    logic load_out;
  } tws_cmd_t;

  typedef struct packed {
    logic req_is_query;
    logic scan_empty;
    logic scan_last;
    logic out_busy;
  } tws_status_t;

endpackage

// ----- design/tws_ctrl.sv -----
// Controller state machine that sequences writes, table scans and result hand-off.
`timescale 1ns / 1ps
module tws_ctrl import tws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  tws_status_t status,
  output tws_cmd_t    cmd
);

  tws_state_t state_r, state_nxt;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && status.req_is_query) begin
          state_nxt = status.scan_empty ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    cmd.write_entry  = 1'b0;
    cmd.start_query  = 1'b0;
    cmd.scan_step    = 1'b0;
    cmd.load_out     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.write_entry = in_valid && !status.req_is_query;
        cmd.start_query = in_valid && status.req_is_query;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.load_out = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_step_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !in_ready && !cmd.load_out)
    else $error("scan step overlaps request intake or result load");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_query |=> (state_r == ST_SCAN) || (state_r == ST_EMIT))
    else $error("query did not start a scan");

  a_emit_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> in_ready)
    else $error("controller did not return to idle after loading a result");

endmodule

// ----- design/tws_datapath.sv -----
// Datapath with the period tables, the scan accumulators and the result register.
`timescale 1ns / 1ps
module tws_datapath import tws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  tws_in_t          in_data,
  input  tws_cmd_t         cmd,
  output tws_status_t      status,
  output logic             out_valid,
  input  logic             out_ready,
  output tws_out_t         out_data
);

  logic [CNT_W-1:0]   scan_count_r;
  logic [PERIODS-1:0] entry_vld_r;
  logic [11:0]        start_r [PERIODS];
  logic [11:0]        end_r   [PERIODS];
  logic [1:0]         type_r  [PERIODS];
  logic signed [15:0] pmin_r  [PERIODS];
  logic signed [15:0] pmax_r  [PERIODS];
  logic signed [7:0]  tlo_r   [PERIODS];
  logic signed [7:0]  thi_r   [PERIODS];

  logic [IDX_W-1:0]   scan_idx_r, last_idx_r, last_idx_nxt;
  logic [11:0]        qtime_r;
  logic signed [11:0] qtemp_r;
  logic [1:0]         act_r, gated_r;
  logic signed [15:0] lo_r, hi_r;
  logic               out_valid_r;
  tws_out_t           out_data_r;

  logic [CNT_W-1:0]   count_clamped;
  logic               rd_vld;
  logic [11:0]        rd_start, rd_end;
  logic [1:0]         rd_type;
  logic signed [15:0] rd_pmin, rd_pmax;
  logic signed [7:0]  rd_tlo, rd_thi;
  logic signed [11:0] tlo_q4, thi_q4;
  logic               time_hit, gate_ok;

  assign count_clamped = (scan_count_r > CNT_W'(PERIODS)) ? CNT_W'(PERIODS) : scan_count_r;
  assign last_idx_nxt  = IDX_W'(count_clamped - CNT_W'(1));

  assign status.req_is_query = (in_data.kind == KIND_QUERY);
  assign status.scan_empty   = (count_clamped == '0);
  assign status.scan_last    = (scan_idx_r == last_idx_r);
  assign status.out_busy     = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      scan_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
    end else if (cmd.write_entry && ({1'b0, in_data.entry_index} < 4'(PERIODS))) begin
      entry_vld_r[in_data.entry_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_entry && ({1'b0, in_data.entry_index} < 4'(PERIODS))) begin
      start_r[in_data.entry_index[IDX_W-1:0]] <= in_data.entry_start;
      end_r[in_data.entry_index[IDX_W-1:0]]   <= in_data.entry_end;
      type_r[in_data.entry_index[IDX_W-1:0]]  <= in_data.entry_type;
      pmin_r[in_data.entry_index[IDX_W-1:0]]  <= in_data.entry_power_min;
      pmax_r[in_data.entry_index[IDX_W-1:0]]  <= in_data.entry_power_max;
      tlo_r[in_data.entry_index[IDX_W-1:0]]   <= in_data.entry_temp_low_limit;
      thi_r[in_data.entry_index[IDX_W-1:0]]   <= in_data.entry_temp_high_limit;
    end
  end

  // An entry that was never written reads as all zero.
  always_comb begin
    rd_vld   = entry_vld_r[scan_idx_r];
    rd_start = rd_vld ? start_r[scan_idx_r] : '0;
    rd_end   = rd_vld ? end_r[scan_idx_r]   : '0;
    rd_type  = rd_vld ? type_r[scan_idx_r]  : '0;
    rd_pmin  = rd_vld ? pmin_r[scan_idx_r]  : '0;
    rd_pmax  = rd_vld ? pmax_r[scan_idx_r]  : '0;
    rd_tlo   = rd_vld ? tlo_r[scan_idx_r]   : '0;
    rd_thi   = rd_vld ? thi_r[scan_idx_r]   : '0;
  end

  assign tlo_q4   = {rd_tlo, 4'b0000};
  assign thi_q4   = {rd_thi, 4'b0000};
  assign time_hit = (qtime_r >= rd_start) && (qtime_r <= rd_end);

  always_comb begin
    gate_ok = 1'b1;
    if (qtemp_r > GATE_FLOOR_Q4) begin
      if ((rd_tlo <= LIMIT_OFF) && (qtemp_r > tlo_q4)) begin
        gate_ok = 1'b0;
      end
      if ((rd_thi <= LIMIT_OFF) && (qtemp_r < thi_q4)) begin
        gate_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      qtime_r    <= in_data.query_time;
      qtemp_r    <= in_data.query_temperature;
      scan_idx_r <= '0;
      last_idx_r <= last_idx_nxt;
      act_r      <= '0;
      gated_r    <= '0;
      lo_r       <= '0;
      hi_r       <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      if (time_hit) begin
        act_r <= rd_type;
        lo_r  <= (rd_type == FORCED_TYPE) ? FORCED_MIN : rd_pmin;
        hi_r  <= (rd_type == FORCED_TYPE) ? FORCED_MAX : rd_pmax;
        if (gate_ok) begin
          gated_r <= rd_type;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.active_type    <= act_r;
      out_data_r.gated_type     <= gated_r;
      out_data_r.threshold_low  <= lo_r;
      out_data_r.threshold_high <= hi_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a pending result");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> scan_idx_r <= last_idx_r)
    else $error("scan index ran past the period count");

endmodule

// ----- design/time_window_schedule_matcher_core.sv -----
// A query scans the first N period entries, N = min(count, 8), then raises out_valid.
// The scan reads one period entry per cycle.
// The emit state repeats while an earlier result still waits on the output.
// A write request gives no result; a new request is taken while a result waits.
// Synchronous active-low reset invalidates all entries, sets the scan count to 1, drops out_valid.
`timescale 1ns / 1ps
module time_window_schedule_matcher_core import tws_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  tws_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tws_out_t         out_data
);

  tws_cmd_t    cmd;
  tws_status_t status;

  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tws_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the time window schedule matcher core.
`timescale 1ns / 1ps
module tb_top;
  import tws_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int SHOW_LIMIT    = 10;

  typedef struct {
    logic [11:0]        win_start;
    logic [11:0]        win_end;
    logic [1:0]         ptype;
    logic signed [15:0] pmin;
    logic signed [15:0] pmax;
    logic signed [7:0]  temp_low;
    logic signed [7:0]  temp_high;
  } period_entry_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  tws_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  tws_out_t         out_data;

  period_entry_t    schedule_shadow[PERIODS];
  logic [CNT_W-1:0] scan_setting;
  tws_out_t         pending_results[$];
  int               error_count = 0;
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               gap_max = 16;
  int               stall_max = 16;

  time_window_schedule_matcher_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic tws_out_t match_schedule(tws_in_t q);
    tws_out_t r;
    int       n;
    int       temp;
    int       lim_low;
    int       lim_high;
    logic     gate_ok;
    r = '0;
    n = (scan_setting > PERIODS) ? PERIODS : scan_setting;
    temp = q.query_temperature;
    for (int i = 0; i < n; i++) begin
      if (q.query_time >= schedule_shadow[i].win_start &&
          q.query_time <= schedule_shadow[i].win_end) begin
        r.active_type = schedule_shadow[i].ptype;
        if (schedule_shadow[i].ptype == FORCED_TYPE) begin
          r.threshold_low  = FORCED_MIN;
          r.threshold_high = FORCED_MAX;
        end else begin
          r.threshold_low  = schedule_shadow[i].pmin;
          r.threshold_high = schedule_shadow[i].pmax;
        end
        gate_ok = 1'b1;
        if (temp > GATE_FLOOR_Q4) begin
          lim_low  = schedule_shadow[i].temp_low;
          lim_high = schedule_shadow[i].temp_high;
          if (lim_low <= LIMIT_OFF && temp > lim_low * 16) gate_ok = 1'b0;
          if (lim_high <= LIMIT_OFF && temp < lim_high * 16) gate_ok = 1'b0;
        end
        if (gate_ok) r.gated_type = schedule_shadow[i].ptype;
      end
    end
    return r;
  endfunction

  task automatic send_request(tws_in_t req);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (req.kind == KIND_QUERY) begin
      pending_results.push_back(match_schedule(req));
    end else if (req.entry_index < PERIODS) begin
      schedule_shadow[req.entry_index] = '{req.entry_start, req.entry_end, req.entry_type,
                                           req.entry_power_min, req.entry_power_max,
                                           req.entry_temp_low_limit,
                                           req.entry_temp_high_limit};
    end
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scan_count(logic [CNT_W-1:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_setting = value;
  endtask

  function automatic tws_in_t random_fill();
    logic [127:0] fill;
    fill = {$urandom(), $urandom(), $urandom(), $urandom()};
    return fill[$bits(tws_in_t)-1:0];
  endfunction

  function automatic tws_in_t make_write(int idx, int st, int en, int ty, int pmin, int pmax,
                                         int lo, int hi);
    tws_in_t r;
    r = random_fill();
    r.kind                  = KIND_WRITE;
    r.entry_index           = 3'(idx);
    r.entry_start           = 12'(st);
    r.entry_end             = 12'(en);
    r.entry_type            = 2'(ty);
    r.entry_power_min       = 16'(pmin);
    r.entry_power_max       = 16'(pmax);
    r.entry_temp_low_limit  = 8'(lo);
    r.entry_temp_high_limit = 8'(hi);
    return r;
  endfunction

  function automatic tws_in_t make_query(int t, int temp);
    tws_in_t r;
    r = random_fill();
    r.kind              = KIND_QUERY;
    r.query_time        = 12'(t);
    r.query_temperature = 12'(temp);
    return r;
  endfunction

  function automatic logic signed [7:0] random_limit();
    case ($urandom_range(0, 9))
      0:       return LIMIT_OFF;
      1:       return LIMIT_OFF + 8'sd1;
      2:       return 8'($urandom_range(102, 127));
      default: return 8'(int'($urandom_range(0, 228)) - 128);
    endcase
  endfunction

  function automatic tws_in_t random_request();
    tws_in_t r;
    int      len;
    int      k;
    int      lim;
    r = random_fill();
    if ($urandom_range(0, 99) < 35) begin
      r.kind        = KIND_WRITE;
      r.entry_start = 12'($urandom_range(0, 4095));
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
      r.entry_end = 12'((r.entry_start + len > 4095) ? 4095 : r.entry_start + len);
      if ($urandom_range(0, 9) == 0 && r.entry_start > 0) begin
        r.entry_end = 12'($urandom_range(0, r.entry_start - 1));
      end
      r.entry_temp_low_limit  = random_limit();
      r.entry_temp_high_limit = random_limit();
    end else begin
      r.kind = KIND_QUERY;
      k = $urandom_range(0, PERIODS - 1);
      case ($urandom_range(0, 5))
        0: r.query_time = schedule_shadow[k].win_start;
        1: r.query_time = schedule_shadow[k].win_end;
        2: r.query_time = schedule_shadow[k].win_start - 12'd1;
        3: r.query_time = schedule_shadow[k].win_end + 12'd1;
        4: r.query_time = 12'($urandom_range(schedule_shadow[k].win_start,
                                             schedule_shadow[k].win_end));
        default: ;
      endcase
      case ($urandom_range(0, 5))
        2: begin
          lim = schedule_shadow[k].temp_low;
          r.query_temperature = 12'(lim * 16 + int'($urandom_range(0, 2)) - 1);
        end
        3: begin
          lim = schedule_shadow[k].temp_high;
          r.query_temperature = 12'(lim * 16 + int'($urandom_range(0, 2)) - 1);
        end
        4: r.query_temperature = 12'(int'(GATE_FLOOR_Q4) + int'($urandom_range(0, 2)) - 1);
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      error_count++;
      if (mismatch_count < SHOW_LIMIT) begin
        $display("Mismatch in %s: expected %h, got %h", name, want, got);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    tws_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (mismatch_count < SHOW_LIMIT) begin
          $display("Unexpected result %h with no query pending", out_data);
        end
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("active_type", want.active_type, out_data.active_type);
        check_field("gated_type", want.gated_type, out_data.gated_type);
        check_field("threshold_low", want.threshold_low, out_data.threshold_low);
        check_field("threshold_high", want.threshold_high, out_data.threshold_high);
      end
    end
  end

  initial begin : result_ready_driver
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic test_reset_state();
    send_request(make_query(0, 0));
    send_request(make_query(4095, -2048));
    send_request(make_query(1, 2047));
  endtask

  task automatic test_entry_extremes();
    write_scan_count(4'd8);
    send_request(make_write(0, 0, 4095, 1, -32768, 32767, 127, -128));
    send_request(make_write(1, 100, 200, 2, 5, 6, 101, 101));
    send_request(make_write(2, 300, 299, 3, 7, 8, 0, 0));
    send_request(make_write(3, 4095, 4095, 3, 32767, -32768, 100, 100));
    send_request(make_write(4, 150, 150, 1, 1000, -1000, 20, -10));
    send_request(make_query(0, -2048));
    send_request(make_query(100, 2047));
    send_request(make_query(200, 0));
    send_request(make_query(150, 320));
    send_request(make_query(150, 321));
    send_request(make_query(150, -1600));
    send_request(make_query(150, -1599));
    send_request(make_query(4095, 1600));
    send_request(make_query(4095, 1601));
    send_request(make_query(4095, 1599));
    send_request(make_query(300, 0));
    send_request(make_query(299, -1601));
  endtask

  task automatic test_scan_count();
    write_scan_count(4'd0);
    send_request(make_query(150, 0));
    write_scan_count(4'd15);
    send_request(make_query(150, 0));
    write_scan_count(4'd2);
    send_request(make_query(150, 0));
    send_request(make_query(100, 0));
  endtask

  task automatic run_traffic(logic [CNT_W-1:0] count, int gaps, int stalls, int items);
    write_scan_count(count);
    gap_max   = gaps;
    stall_max = stalls;
    repeat (items) send_request(random_request());
  endtask

  task automatic test_random_traffic();
    run_traffic(4'd8, 16, 16, 400);
    run_traffic(4'd1, 16, 0, 200);
    run_traffic(4'd0, 0, 16, 100);
    run_traffic(4'd15, 0, 0, 250);
    run_traffic(4'($urandom_range(0, 15)), 16, 16, 300);
    run_traffic(4'd3, 16, 16, 200);
    run_traffic(4'd8, 0, 0, 300);
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    for (int i = 0; i < PERIODS; i++) schedule_shadow[i] = '{default: '0};
    scan_setting = 4'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_entry_extremes();
    test_scan_count();
    test_random_traffic();
    settle_block();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tws_pkg.sv
design/tws_ctrl.sv
design/tws_datapath.sv
design/time_window_schedule_matcher_core.sv
tb/tb_top.sv
